// ===== hw/rtl/pvc_pkg.sv =====
// ----------------------------------------------------------------------------
// pvc_pkg: shared types and constants for the viscoelastic contact block
// Register indexes, arithmetic widths and saturation helpers.
// ----------------------------------------------------------------------------
`default_nettype none

package pvc_pkg;

	localparam int NUM_TERMS_DEF = 3;

	// configuration register indexes
	localparam logic [2:0] REG_BINDER_K   = 3'd0;
	localparam logic [2:0] REG_PARTICLE_K = 3'd1;
	localparam logic [2:0] REG_BINDER_T   = 3'd2;
	localparam logic [2:0] REG_YIELD      = 3'd3;
	localparam logic [2:0] REG_MODE       = 3'd4;
	localparam logic [2:0] REG_TERM0      = 3'd5;

	localparam int CFG_W   = 63;
	localparam int MAC_AW  = 41;   // signed multiplicand
	localparam int MAC_BW  = 36;   // unsigned multiplier
	localparam int MAC_DW  = 9;    // multiplier digit per cycle
	localparam int MAC_ND  = MAC_BW / MAC_DW;
	localparam int ACC_W   = 80;
	localparam int SQ_XW   = 56;
	localparam int SQ_RW   = SQ_XW / 2;

	typedef struct packed {
		logic start;
		logic clr;
		logic sub;
	} mac_req_t;

	function automatic logic signed [47:0] sat48(input logic signed [57:0] v);
		logic signed [57:0] hi;
		logic signed [57:0] lo;
		hi = 58'sh0_7FFF_FFFF_FFFF;
		lo = -hi - 58'sd1;
		if (v > hi) begin
			sat48 = hi[47:0];
		end else if (v < lo) begin
			sat48 = lo[47:0];
		end else begin
			sat48 = v[47:0];
		end
	endfunction

	function automatic logic signed [31:0] sat32(input logic signed [37:0] v);
		logic signed [37:0] hi;
		logic signed [37:0] lo;
		hi = 38'sh7FFF_FFFF;
		lo = -hi - 38'sd1;
		if (v > hi) begin
			sat32 = hi[31:0];
		end else if (v < lo) begin
			sat32 = lo[31:0];
		end else begin
			sat32 = v[31:0];
		end
	endfunction

endpackage

`default_nettype wire

// ===== hw/rtl/pvc_mac.sv =====
// ----------------------------------------------------------------------------
// pvc_mac: digit-serial multiply-accumulate unit
// Adds or subtracts a signed by unsigned product to an 80-bit accumulator,
// one 9-bit multiplier digit per cycle.
// ----------------------------------------------------------------------------
`default_nettype none

module pvc_mac (
	input  wire                                     clk,
	input  wire                                     arst_n,
	input  wire pvc_pkg::mac_req_t                  req,
	input  wire logic signed [pvc_pkg::MAC_AW-1:0]  a,
	input  wire logic [pvc_pkg::MAC_BW-1:0]         b,
	input  wire logic signed [pvc_pkg::ACC_W-1:0]   init,
	output logic                                    busy,
	output logic signed [pvc_pkg::ACC_W-1:0]        acc
);
	import pvc_pkg::*;

	localparam int PW = MAC_AW + MAC_DW;

	logic signed [MAC_AW-1:0] a_q;
	logic [MAC_BW-1:0]        b_q;
	logic                     sub_q;
	logic [1:0]               cnt_q;
	logic                     busy_q;
	logic signed [ACC_W-1:0]  acc_q;

	logic [MAC_DW-1:0]        digit;
	logic signed [PW-1:0]     partial;
	logic signed [ACC_W-1:0]  pp_ext;
	logic [6:0]               shamt;

	always_comb begin
		digit   = b_q[cnt_q*MAC_DW +: MAC_DW];
		partial = a_q * $signed({1'b0, digit});
		pp_ext  = {{(ACC_W-PW){partial[PW-1]}}, partial};
		shamt   = 7'(cnt_q) * 7'(MAC_DW);
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			busy_q <= 1'b0;
			cnt_q  <= '0;
		end else if (req.start) begin
			busy_q <= 1'b1;
			cnt_q  <= '0;
		end else if (busy_q) begin
			cnt_q <= cnt_q + 2'd1;
			if (cnt_q == 2'(MAC_ND - 1)) begin
				busy_q <= 1'b0;
			end
		end
	end

	always_ff @(posedge clk) begin
		if (req.start) begin
			a_q   <= a;
			b_q   <= b;
			sub_q <= req.sub;
			if (req.clr) begin
				acc_q <= init;
			end
		end else if (busy_q) begin
			if (sub_q) begin
				acc_q <= acc_q - (pp_ext <<< shamt);
			end else begin
				acc_q <= acc_q + (pp_ext <<< shamt);
			end
		end
	end

	assign busy = busy_q;
	assign acc  = acc_q;

endmodule

`default_nettype wire

// ===== hw/rtl/pvc_isqrt.sv =====
// ----------------------------------------------------------------------------
// pvc_isqrt: bit-serial integer square root
// Floor root of a 56-bit value, one result bit per cycle.
// ----------------------------------------------------------------------------
`default_nettype none

module pvc_isqrt (
	input  wire                              clk,
	input  wire                              arst_n,
	input  wire                              start,
	input  wire logic [pvc_pkg::SQ_XW-1:0]   x,
	output logic                             busy,
	output logic [pvc_pkg::SQ_RW-1:0]        root
);
	import pvc_pkg::*;

	logic [SQ_XW-1:0] x_q;
	logic [SQ_RW+1:0] rem_q;
	logic [SQ_RW-1:0] root_q;
	logic [4:0]       cnt_q;
	logic             busy_q;

	logic [SQ_RW+3:0] rem_n;
	logic [SQ_RW+3:0] trial;

	always_comb begin
		rem_n = {rem_q, x_q[SQ_XW-1 -: 2]};
		trial = {2'b00, root_q, 2'b01};
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			busy_q <= 1'b0;
			cnt_q  <= '0;
		end else if (start) begin
			busy_q <= 1'b1;
			cnt_q  <= '0;
		end else if (busy_q) begin
			cnt_q <= cnt_q + 5'd1;
			if (cnt_q == 5'(SQ_RW - 1)) begin
				busy_q <= 1'b0;
			end
		end
	end

	always_ff @(posedge clk) begin
		if (start) begin
			x_q    <= x;
			rem_q  <= '0;
			root_q <= '0;
		end else if (busy_q) begin
			x_q <= x_q << 2;
			if (rem_n >= trial) begin
				rem_q  <= (SQ_RW+2)'(rem_n - trial);
				root_q <= {root_q[SQ_RW-2:0], 1'b1};
			end else begin
				rem_q  <= rem_n[SQ_RW+1:0];
				root_q <= {root_q[SQ_RW-2:0], 1'b0};
			end
		end
	end

	assign busy = busy_q;
	assign root = root_q;

endmodule

`default_nettype wire

// ===== hw/rtl/prony_viscoelastic_contact_force_top.sv =====
// ----------------------------------------------------------------------------
// prony_viscoelastic_contact_force_top: viscoelastic binder + Hertz contact
// Normal force of one contact, updated once per overlap sample.
// ----------------------------------------------------------------------------
// Usage:
//   Input stream (s_*) carries one overlap sample per transaction, signed
//   Q8.24. Output stream (m_*) returns one transaction per sample: total,
//   viscous and particle force (signed 48-bit) and the binder flag.
//   Configuration is written through cfg_wr_* while the block is idle.
// Sequencing:
//   One sample at a time; s_tready is high only when the sequencer idles.
//   All products go through one digit-serial multiply-accumulate unit,
//   each product followed by a wait step. A sample runs the strain update
//   for each active Prony term, the force increment for each term (at
//   least one), the viscous sum and the particle sum, plus one entry and
//   one output step. The square root starts at acceptance and holds back
//   the particle path. A non-positive overlap with no binder update runs
//   no products.
// Reset:
//   arst_n clears sequencer state, sums, strains and configuration to zero.
// Stall:
//   A finished result waits in the output register; while m_tready is low
//   the next result is held back in the sequencer, which takes no new input.
// ----------------------------------------------------------------------------
`default_nettype none

module prony_viscoelastic_contact_force_top #(
	parameter int NUM_TERMS = pvc_pkg::NUM_TERMS_DEF
) (
	input  wire                              clk,
	input  wire                              arst_n,
	// input stream: tdata = overlap[31:0]
	input  wire                              s_tvalid,
	output logic                             s_tready,
	input  wire logic [31:0]                 s_tdata,
	// output stream: tdata = normal_force[47:0], viscous_force[95:48],
	// particle_force[143:96], binder_active[144], zero fill[151:145]
	output logic                             m_tvalid,
	input  wire                              m_tready,
	output logic [151:0]                     m_tdata,
	// configuration write port
	input  wire                              cfg_wr_en,
	input  wire logic [2:0]                  cfg_wr_index,
	input  wire logic [pvc_pkg::CFG_W-1:0]   cfg_wr_data
);
	import pvc_pkg::*;

	localparam int IW = (NUM_TERMS > 1) ? $clog2(NUM_TERMS) : 1;
	localparam logic [1:0] NT2 = 2'(NUM_TERMS);

	// sequencer states
	localparam logic [3:0] S_IDLE = 4'd0;
	localparam logic [3:0] S_PB   = 4'd1;
	localparam logic [3:0] S_PA   = 4'd2;
	localparam logic [3:0] S_DD   = 4'd3;
	localparam logic [3:0] S_FA   = 4'd4;
	localparam logic [3:0] S_VM   = 4'd5;
	localparam logic [3:0] S_VS   = 4'd6;
	localparam logic [3:0] S_KM   = 4'd7;
	localparam logic [3:0] S_KD   = 4'd8;
	localparam logic [3:0] S_PS   = 4'd9;
	localparam logic [3:0] S_OUT  = 4'd10;
	localparam logic [3:0] S_MW   = 4'd11;

	// configuration
	logic [31:0] kb_q, kp_q;
	logic [30:0] bt_q, hy_q;
	logic [3:0]  mode_q;
	logic [CFG_W-1:0] coef_q [NUM_TERMS];

	// contact state
	logic signed [31:0] last_q, peak_q;
	logic               act_q;
	logic signed [47:0] visc_q, part_q;
	logic signed [31:0] strain_q [NUM_TERMS];
	logic signed [36:0] dd_q [NUM_TERMS];

	// per-sample working registers
	logic [3:0]         state_q, nxt_q;
	logic signed [32:0] dh_q;
	logic signed [31:0] h_q;
	logic               hpos_q;
	logic [1:0]         m_q;
	logic [IW-1:0]      i_q;

	// output register
	logic               out_v_q;
	logic [151:0]       out_q;

	// shared units
	mac_req_t                mreq;
	logic signed [MAC_AW-1:0] ma;
	logic [MAC_BW-1:0]       mb;
	logic signed [ACC_W-1:0] minit;
	logic                    mbusy;
	logic signed [ACC_W-1:0] macc;
	logic                    sq_start;
	logic [SQ_XW-1:0]        sq_x;
	logic                    sq_busy;
	logic [SQ_RW-1:0]        sq_root;

	pvc_mac u_mac (
		.clk   (clk),
		.arst_n(arst_n),
		.req   (mreq),
		.a     (ma),
		.b     (mb),
		.init  (minit),
		.busy  (mbusy),
		.acc   (macc)
	);

	pvc_isqrt u_sqrt (
		.clk   (clk),
		.arst_n(arst_n),
		.start (sq_start),
		.x     (sq_x),
		.busy  (sq_busy),
		.root  (sq_root)
	);

	// combinational helpers
	logic               accept;
	logic               out_load;
	logic signed [31:0] h_in;
	logic signed [32:0] dh_in;
	logic signed [31:0] peak_new;
	logic               bind_go;
	logic [1:0]         m_in;
	logic [20:0]        co_a, co_b, co_al;
	logic signed [33:0] e_i;
	logic signed [ACC_W-1:0] sh16, sh20, sh24;
	logic signed [57:0] visc_sum, part_sum;
	logic signed [48:0] tot;
	logic signed [47:0] pc, vc;
	logic               last_term;

	always_comb begin
		accept   = s_tvalid && s_tready;
		out_load = (state_q == S_OUT) && (!out_v_q || m_tready);
		h_in     = $signed(s_tdata);
		dh_in    = {h_in[31], h_in} - {last_q[31], last_q};
		peak_new = (h_in > peak_q) ? h_in : peak_q;
		bind_go  = mode_q[0] &&
			(($signed({h_in[31], h_in}) > -$signed({2'b00, bt_q})) || act_q);
		m_in     = (mode_q[3:2] > NT2) ? NT2 : mode_q[3:2];
		co_a     = coef_q[i_q][20:0];
		co_b     = coef_q[i_q][41:21];
		co_al    = coef_q[i_q][62:42];
		e_i      = {{2{h_q[31]}}, h_q} + {3'b000, bt_q}
			- {{2{strain_q[i_q][31]}}, strain_q[i_q]};
		sh16     = macc >>> 16;
		sh20     = macc >>> 20;
		sh24     = macc >>> 24;
		visc_sum = {{10{visc_q[47]}}, visc_q} + sh16[57:0];
		part_sum = {{10{part_q[47]}}, part_q} + sh16[57:0];
		last_term = (m_q == 2'd0) || (2'(i_q) + 2'd1 == m_q);
		pc       = (part_q > 48'sd0) ? part_q : '0;
		vc       = (!mode_q[1] && visc_q < 48'sd0) ? '0 : visc_q;
		tot      = {pc[47], pc} + {vc[47], vc};
		// launch the root as soon as the sample arrives
		sq_start = accept;
		if ((h_in > $signed({1'b0, hy_q})) && (h_in >= peak_new)) begin
			sq_x = {1'b0, hy_q, 24'b0};
		end else begin
			sq_x = {h_in, 24'b0};
		end
	end

	// drive the shared multiply-accumulate unit per step
	always_comb begin
		mreq  = '0;
		ma    = '0;
		mb    = '0;
		minit = '0;
		unique case (state_q)
			S_PB: begin
				mreq  = '{start: 1'b1, clr: 1'b1, sub: 1'b0};
				ma    = MAC_AW'(dh_q);
				mb    = MAC_BW'(co_b);
				minit = ACC_W'(1 << 19);
			end
			S_PA: begin
				mreq = '{start: 1'b1, clr: 1'b0, sub: 1'b0};
				ma   = MAC_AW'(e_i);
				mb   = MAC_BW'(co_a);
			end
			S_FA: begin
				mreq  = '{start: 1'b1, clr: (i_q == '0), sub: 1'b1};
				ma    = (m_q == 2'd0) ? '0 : MAC_AW'(dd_q[i_q]);
				mb    = MAC_BW'(co_al);
				minit = {{(ACC_W-53){dh_q[32]}}, dh_q, 20'b0} + ACC_W'(1 << 19);
			end
			S_VM: begin
				mreq  = '{start: 1'b1, clr: 1'b1, sub: 1'b0};
				ma    = sh20[MAC_AW-1:0];
				mb    = MAC_BW'(kb_q);
				minit = ACC_W'(1 << 15);
			end
			S_KM: begin
				mreq  = '{start: (hpos_q && !sq_busy), clr: 1'b1, sub: 1'b0};
				ma    = MAC_AW'({1'b0, sq_root});
				mb    = MAC_BW'(kp_q);
				minit = ACC_W'(1 << 23);
			end
			S_KD: begin
				mreq  = '{start: 1'b1, clr: 1'b1, sub: 1'b0};
				ma    = MAC_AW'(dh_q);
				mb    = sh24[MAC_BW-1:0];
				minit = ACC_W'(1 << 15);
			end
			default: begin
				mreq = '0;
			end
		endcase
	end

	// configuration writes; indexes beyond the list fall through
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			kb_q   <= '0;
			kp_q   <= '0;
			bt_q   <= '0;
			hy_q   <= '0;
			mode_q <= '0;
			for (int t = 0; t < NUM_TERMS; t++) begin
				coef_q[t] <= '0;
			end
		end else if (cfg_wr_en) begin
			if (cfg_wr_index == REG_BINDER_K) kb_q <= cfg_wr_data[31:0];
			if (cfg_wr_index == REG_PARTICLE_K) kp_q <= cfg_wr_data[31:0];
			if (cfg_wr_index == REG_BINDER_T) bt_q <= cfg_wr_data[30:0];
			if (cfg_wr_index == REG_YIELD) hy_q <= cfg_wr_data[30:0];
			if (cfg_wr_index == REG_MODE) mode_q <= cfg_wr_data[3:0];
			for (int t = 0; t < NUM_TERMS; t++) begin
				if (cfg_wr_index == REG_TERM0 + 3'(t)) coef_q[t] <= cfg_wr_data;
			end
		end
	end

	// sequencer and contact state
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q <= S_IDLE;
			nxt_q   <= S_IDLE;
			last_q  <= '0;
			peak_q  <= '0;
			act_q   <= 1'b0;
			visc_q  <= '0;
			part_q  <= '0;
			i_q     <= '0;
			out_v_q <= 1'b0;
			for (int t = 0; t < NUM_TERMS; t++) begin
				strain_q[t] <= '0;
			end
		end else begin
			if (out_load) begin
				out_v_q <= 1'b1;
			end else if (m_tready) begin
				out_v_q <= 1'b0;
			end
			unique case (state_q)
				S_IDLE: begin
					if (accept) begin
						h_q    <= h_in;
						dh_q   <= dh_in;
						last_q <= h_in;
						peak_q <= peak_new;
						hpos_q <= (h_in > 32'sd0);
						m_q    <= m_in;
						i_q    <= '0;
						if (!bind_go) begin
							state_q <= S_KM;
						end else if (m_in == 2'd0) begin
							state_q <= S_FA;
						end else begin
							state_q <= S_PB;
						end
					end
				end
				S_PB: begin
					nxt_q   <= S_PA;
					state_q <= S_MW;
				end
				S_PA: begin
					nxt_q   <= S_DD;
					state_q <= S_MW;
				end
				S_DD: begin
					// commit strain increment for this term
					dd_q[i_q]     <= sh20[36:0];
					strain_q[i_q] <= sat32({{6{strain_q[i_q][31]}}, strain_q[i_q]}
						+ {sh20[36], sh20[36:0]});
					if (last_term) begin
						i_q     <= '0;
						state_q <= S_FA;
					end else begin
						i_q     <= i_q + IW'(1);
						state_q <= S_PB;
					end
				end
				S_FA: begin
					if (last_term) begin
						i_q   <= '0;
						nxt_q <= S_VM;
					end else begin
						i_q   <= i_q + IW'(1);
						nxt_q <= S_FA;
					end
					state_q <= S_MW;
				end
				S_VM: begin
					nxt_q   <= S_VS;
					state_q <= S_MW;
				end
				S_VS: begin
					visc_q  <= sat48(visc_sum);
					act_q   <= 1'b1;
					state_q <= S_KM;
				end
				S_KM: begin
					if (!hpos_q) begin
						part_q  <= '0;
						state_q <= S_OUT;
					end else if (!sq_busy) begin
						nxt_q   <= S_KD;
						state_q <= S_MW;
					end
				end
				S_KD: begin
					nxt_q   <= S_PS;
					state_q <= S_MW;
				end
				S_PS: begin
					part_q  <= sat48(part_sum);
					state_q <= S_OUT;
				end
				S_OUT: begin
					// hold until the output register is free
					if (out_load) begin
						out_q   <= {7'b0, act_q, part_q, visc_q, sat48(58'(tot))};
						state_q <= S_IDLE;
					end
				end
				S_MW: begin
					if (!mbusy) begin
						state_q <= nxt_q;
					end
				end
				default: begin
					state_q <= S_IDLE;
				end
			endcase
		end
	end

	assign s_tready = (state_q == S_IDLE);
	assign m_tvalid = out_v_q;
	assign m_tdata  = out_q;

endmodule

`default_nettype wire
